/* sv/fmprs_pkg.sv */
// ----------------------------------------------------------------------------
// fmprs_pkg
// Shared types, codes and helpers of the four motor pull/hold/rewind sequencer.
// ----------------------------------------------------------------------------
package fmprs_pkg;

	localparam int MOTORS_MAX = 4;
	localparam int MOTORS_DEF = 4;
	localparam int NPAR       = 8;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [2:0] P_PERIOD = 3'd0;
	localparam logic [2:0] P_PULL_T = 3'd1;
	localparam logic [2:0] P_PULL_F = 3'd2;
	localparam logic [2:0] P_HOLD_T = 3'd3;
	localparam logic [2:0] P_HOLD_F = 3'd4;
	localparam logic [2:0] P_REW_T  = 3'd5;
	localparam logic [2:0] P_REW_F  = 3'd6;
	localparam logic [2:0] P_START  = 3'd7;

	typedef enum logic [2:0] {
		PH_PULL    = 3'd0,
		PH_HOLD    = 3'd1,
		PH_REWIND  = 3'd2,
		PH_WAIT    = 3'd3,
		PH_RESTART = 3'd4,
		PH_INIT    = 3'd5
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] time_ms;
		logic [1:0]  motor_index;
		logic [2:0]  param_index;
		logic [15:0] param_value;
	} req_in_t;

	typedef struct packed {
		logic [7:0] dir_motor0;
		logic [7:0] force_motor0;
		logic [7:0] dir_motor1;
		logic [7:0] force_motor1;
		logic [7:0] dir_motor2;
		logic [7:0] force_motor2;
		logic [7:0] dir_motor3;
		logic [7:0] force_motor3;
	} req_out_t;

	function automatic logic [7:0] sat8(input logic [15:0] v);
		logic [7:0] r;
		r = (v > 16'd255) ? 8'hff : v[7:0];
		return r;
	endfunction

endpackage

/* sv/fmprs_motor.sv */
// ----------------------------------------------------------------------------
// fmprs_motor
// One motor channel: shadow and working parameter sets, phase sequencer, drive.
// ----------------------------------------------------------------------------
module fmprs_motor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  param_index,
	input  logic [15:0] param_value,
	input  logic        tick_en,
	input  logic [31:0] time_ms,
	output logic [7:0]  drv_dir,
	output logic [7:0]  drv_force
);

	fmprs_pkg::phase_t phase_q, phase_d;
	logic [31:0] start_q;
	logic [15:0] shadow_q [fmprs_pkg::NPAR];
	logic [15:0] work_q   [fmprs_pkg::NPAR];
	logic [7:0]  dir_q, dir_d;
	logic [7:0]  force_q, force_d;

	logic [31:0] elapsed;
	logic [31:0] lim_pull;
	logic [31:0] lim_hold;
	logic [31:0] lim_rew;
	logic [31:0] lim_period;

	assign elapsed    = time_ms - start_q;
	assign lim_pull   = {16'd0, work_q[fmprs_pkg::P_PULL_T]};
	assign lim_hold   = lim_pull + {16'd0, work_q[fmprs_pkg::P_HOLD_T]};
	assign lim_rew    = lim_hold + {16'd0, work_q[fmprs_pkg::P_REW_T]};
	assign lim_period = {16'd0, work_q[fmprs_pkg::P_PERIOD]};

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			fmprs_pkg::PH_INIT: begin
				if (shadow_q[fmprs_pkg::P_PERIOD] != 16'd0 &&
				    shadow_q[fmprs_pkg::P_START] != 16'd0) begin
					phase_d = fmprs_pkg::PH_PULL;
				end
			end
			fmprs_pkg::PH_PULL: begin
				if (elapsed > lim_pull) begin
					phase_d = fmprs_pkg::PH_HOLD;
				end
			end
			fmprs_pkg::PH_HOLD: begin
				if (elapsed > lim_hold) begin
					phase_d = fmprs_pkg::PH_REWIND;
				end
			end
			fmprs_pkg::PH_REWIND: begin
				if (elapsed > lim_rew) begin
					phase_d = fmprs_pkg::PH_WAIT;
				end
			end
			fmprs_pkg::PH_WAIT: begin
				if (elapsed >= lim_period) begin
					phase_d = fmprs_pkg::PH_RESTART;
				end
			end
			fmprs_pkg::PH_RESTART: begin
				phase_d = fmprs_pkg::PH_INIT;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// drive for the current phase
	always_comb begin
		dir_d   = dir_q;
		force_d = force_q;
		case (phase_q)
			fmprs_pkg::PH_PULL: begin
				dir_d   = fmprs_pkg::sat8(work_q[fmprs_pkg::P_START]);
				force_d = fmprs_pkg::sat8(work_q[fmprs_pkg::P_PULL_F]);
			end
			fmprs_pkg::PH_HOLD: begin
				dir_d   = fmprs_pkg::sat8(work_q[fmprs_pkg::P_START]);
				force_d = fmprs_pkg::sat8(work_q[fmprs_pkg::P_HOLD_F]);
			end
			fmprs_pkg::PH_REWIND: begin
				dir_d   = fmprs_pkg::sat8(work_q[fmprs_pkg::P_START]);
				force_d = fmprs_pkg::sat8(work_q[fmprs_pkg::P_REW_F]);
			end
			fmprs_pkg::PH_WAIT, fmprs_pkg::PH_RESTART: begin
				dir_d   = 8'd0;
				force_d = 8'd0;
			end
			default: begin
				dir_d   = dir_q;
				force_d = force_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fmprs_pkg::PH_INIT;
			start_q <= 32'd0;
			dir_q   <= 8'd0;
			force_q <= 8'd0;
			for (int i = 0; i < fmprs_pkg::NPAR; i++) begin
				shadow_q[i] <= 16'd0;
				work_q[i]   <= 16'd0;
			end
		end else begin
			if (wr_en) begin
				shadow_q[param_index] <= param_value;
			end
			if (tick_en) begin
				phase_q <= phase_d;
				dir_q   <= dir_d;
				force_q <= force_d;
				if (phase_q == fmprs_pkg::PH_INIT) begin
					start_q <= time_ms;
					for (int i = 0; i < fmprs_pkg::NPAR; i++) begin
						work_q[i] <= shadow_q[i];
					end
				end
			end
		end
	end

	// drive that the next tick leaves held
	assign drv_dir   = dir_d;
	assign drv_force = force_d;

endmodule

/* sv/four_motor_pull_hold_rewind_sequencer.sv */
// ----------------------------------------------------------------------------
// four_motor_pull_hold_rewind_sequencer
// Parameter writes and millisecond ticks drive four pull/hold/rewind motors.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload          | moves
//  ---------+----------------------+------------------+---------------------------
//  in       | in_valid / in_ready  | in_req  (req_in) | tick or parameter write
//  out      | out_valid / out_ready| out_req (req_out)| drive of all motors, 1/tick
//
//  One request per cycle while no tick stalls; an accepted tick's result passes
//  the input register, then the result register, before it is valid.
//  Writes produce no result and never wait on the output side.
//  A tick stalls in the input register only while an untaken result is held.
//  Reset puts every motor in period init with zero parameters and drive.
// ----------------------------------------------------------------------------
module four_motor_pull_hold_rewind_sequencer #(
	parameter int MOTORS = fmprs_pkg::MOTORS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fmprs_pkg::req_in_t  in_req,
	output logic                out_valid,
	input  logic                out_ready,
	output fmprs_pkg::req_out_t out_req
);

	logic                valid_s1_q;
	fmprs_pkg::req_in_t  req_s1;
	logic                out_valid_q;
	fmprs_pkg::req_out_t out_q;
	fmprs_pkg::req_out_t res;

	logic is_tick;
	logic advance;
	logic [7:0] dir_w   [fmprs_pkg::MOTORS_MAX];
	logic [7:0] force_w [fmprs_pkg::MOTORS_MAX];

	assign is_tick  = req_s1.kind == fmprs_pkg::KIND_TICK;
	assign advance  = valid_s1_q && (!is_tick || !out_valid_q || out_ready);
	assign in_ready = !valid_s1_q || advance;

	for (genvar m = 0; m < fmprs_pkg::MOTORS_MAX; m++) begin : g_motor
		if (m < MOTORS) begin : g_on
			fmprs_motor u_motor (
				.clk         (clk),
				.arst_n      (arst_n),
				.wr_en       (advance && !is_tick && req_s1.motor_index == 2'(m)),
				.param_index (req_s1.param_index),
				.param_value (req_s1.param_value),
				.tick_en     (advance && is_tick),
				.time_ms     (req_s1.time_ms),
				.drv_dir     (dir_w[m]),
				.drv_force   (force_w[m])
			);
		end else begin : g_off
			assign dir_w[m]   = 8'd0;
			assign force_w[m] = 8'd0;
		end
	end

	// result reflects drive after this tick's update
	logic [7:0] dir_nx   [fmprs_pkg::MOTORS_MAX];
	logic [7:0] force_nx [fmprs_pkg::MOTORS_MAX];
	assign dir_nx   = dir_w;
	assign force_nx = force_w;

	always_comb begin
		res.dir_motor0   = dir_nx[0];
		res.force_motor0 = force_nx[0];
		res.dir_motor1   = dir_nx[1];
		res.force_motor1 = force_nx[1];
		res.dir_motor2   = dir_nx[2];
		res.force_motor2 = force_nx[2];
		res.dir_motor3   = dir_nx[3];
		res.force_motor3 = force_nx[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1_q <= in_valid;
			end
			if (advance && is_tick) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_req;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_tick) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_q;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1_q && !advance |=> valid_s1_q && $stable(req_s1))
		else $error("input stage lost or changed a stalled request");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_tick |=> out_valid_q)
		else $error("accepted tick did not load a result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(advance && is_tick))
		else $error("tick advanced over an untaken result");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_tick && !out_valid_q |=> !out_valid_q)
		else $error("write produced a result");

endmodule
